/* hw/rtl/htmru_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package htmru_pkg;
  localparam logic [1:0] OP_FIND = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [1:0] ST_MISS   = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [10:0] TABLE_SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [12:0] entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FILL_RD, S_FILL_WAIT, S_SCAN_RD, S_SCAN_CHK,
    S_SHIFT_RD, S_SHIFT_WR, S_FRONT, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [10:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/htmru_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// Restoring modulo, one quotient bit per cycle.
module htmru_mod
  import htmru_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [31:0] num;
  logic [11:0] rem;
  logic [10:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [11:0] trial;
  logic [11:0] sub;

  assign trial = {rem[10:0], num[31]};
  assign sub   = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        num  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        num <= {num[30:0], 1'b0};
        rem <= sub[11] ? trial : sub;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = {4'd0, rem};
endmodule
`default_nettype wire

/* hw/rtl/hash_table_mru_buckets.sv */
`timescale 1ns / 1ps
`default_nettype none
// Keyed store with most-recently-used ordered buckets.
// Input channel (in_valid/in_stall/in_data) takes one find, add, delete or
// no-op item; the output channel (out_valid/out_stall/out_data) returns one
// result item for each. Configuration goes through an APB-style port;
// register 0 at byte address 0 holds table_size and should be written only
// when idle. Items are handled one at a time. An item passes through the
// bucket modulo in the serial divider, a read of the bucket fill, a read and
// a compare for each way checked in the key memory (plus a step to end a
// scan that misses), a read and a write for each entry moved plus a step to
// end the moves, a front write and a load of the result into the output
// register. The next item is taken once the block is back in idle.
// The result waits in an output register; while out_stall is high the next
// item may still be accepted and run up to its completion, then waits.
// Reset clears the fill counters by a pass over SLOTS entries, one per cycle,
// during which no item is accepted. Key and value memories need no clearing.
module hash_table_mru_buckets
  import htmru_pkg::*;
#(
  parameter int SLOTS = 1024,
  parameter int WAYS  = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output rsp_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = $clog2(WAYS + 1);
  localparam int DEPTH = SLOTS * WAYS;
  localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam logic [10:0] SLOTS_C = (SLOTS > 2047) ? 11'd2047 : 11'(SLOTS);

  logic [63:0] key_mem [DEPTH];
  logic [31:0] val_mem [DEPTH];
  logic [FW-1:0] fill_mem [SLOTS];

  logic [10:0] table_size;
  state_t state, state_next;
  req_t   cur;
  logic [SW-1:0] bucket;
  logic [FW-1:0] fill;
  logic [FW-1:0] w;
  logic [FW-1:0] j;
  logic [12:0] total;
  logic [63:0] key_rd;
  logic [31:0] val_rd;
  logic [63:0] hold_key;
  logic [31:0] hold_val;
  logic        found;
  logic        clearing;
  logic [SW:0] clr_idx;
  rsp_t  res;
  logic  res_pend;
  logic  done_go;

  div_req_t dreq;
  div_rsp_t drsp;
  htmru_mod u_mod (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [10:0] eff_size;
  assign eff_size = (table_size == 11'd0) ? 11'd1
                  : (table_size > SLOTS_C) ? SLOTS_C : table_size;

  logic accept;
  assign in_stall = clearing || (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign dreq.start = accept;
  assign dreq.dividend = in_data.key[31:0];
  assign dreq.divisor = eff_size;

  // The finished item moves into the output register once that is free.
  assign done_go = (state == S_DONE) && (!res_pend || !out_stall);

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TABLE_SIZE) ? {21'd0, table_size} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) table_size <= TABLE_SIZE_RESET;
    else if (psel && penable && pwrite && paddr == REG_TABLE_SIZE)
      table_size <= pwdata[10:0];
  end

  // Memory address and write controls.
  logic [AW-1:0] base;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [63:0]   wr_key;
  logic [31:0]   wr_val;
  logic          fill_we;
  logic [FW-1:0] fill_wd;
  logic [SW-1:0] fill_wa;
  logic [FW-1:0] fill_rd;
  logic [1:0]    res_status;
  logic          is_add_new;
  logic          do_shift;

  assign base = AW'(bucket) * AW'(WAYS);
  assign is_add_new = (cur.op == OP_ADD) && !found;
  // Insert shifts all of fill down by one; a hit shifts the entries ahead
  // of it; a delete shifts entries after the hit up.

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_DIV;
      S_DIV:       if (drsp.done) state_next = S_FILL_RD;
      S_FILL_RD:   state_next = S_FILL_WAIT;
      S_FILL_WAIT: state_next = (cur.op == OP_FIND || cur.op == OP_ADD
                                 || cur.op == OP_DEL) ? S_SCAN_RD : S_DONE;
      S_SCAN_RD:   state_next = (w < fill) ? S_SCAN_CHK
                              : (is_add_new && fill < FW'(WAYS)) ? S_SHIFT_RD
                              : S_FRONT;
      S_SCAN_CHK:  state_next = (key_rd == cur.key) ? S_SHIFT_RD : S_SCAN_RD;
      S_SHIFT_RD:  state_next = do_shift ? S_SHIFT_WR : S_FRONT;
      S_SHIFT_WR:  state_next = S_SHIFT_RD;
      S_FRONT:     state_next = S_DONE;
      S_DONE:      state_next = done_go ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // do_shift: delete moves j+1 -> j for j+1 < fill; others move j-1 -> j
  always_comb begin
    if (cur.op == OP_DEL && found)
      do_shift = (FW+1)'(j) + (FW+1)'(1) < (FW+1)'(fill);
    else do_shift = j != '0;
  end

  always_comb begin
    rd_addr = base + AW'(w);
    if (state == S_SHIFT_RD) begin
      if (cur.op == OP_DEL && found) rd_addr = base + AW'(j) + AW'(1);
      else rd_addr = base + AW'(j) - AW'(1);
    end
    if (state == S_SCAN_CHK && key_rd == cur.key) rd_addr = base + AW'(w) - AW'(1);
    wr_en = 1'b0;
    wr_addr = base + AW'(j);
    wr_key = key_rd;
    wr_val = val_rd;
    if (state == S_SHIFT_WR) wr_en = 1'b1;
    if (state == S_FRONT && !(cur.op == OP_DEL && found)
        && (found || (is_add_new && fill < FW'(WAYS)))) begin
      wr_en = 1'b1;
      wr_addr = base;
      wr_key = found ? hold_key : cur.key;
      wr_val = (cur.op == OP_ADD) ? cur.value_in : hold_val;
    end
  end

  always_ff @(posedge clk) begin
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_comb begin
    fill_we = 1'b0;
    fill_wa = bucket;
    fill_wd = fill;
    if (clearing) begin
      fill_we = 1'b1;
      fill_wa = clr_idx[SW-1:0];
      fill_wd = '0;
    end else if (state == S_FRONT) begin
      if (cur.op == OP_DEL && found) begin
        fill_we = 1'b1;
        fill_wd = fill - FW'(1);
      end else if (is_add_new && fill < FW'(WAYS)) begin
        fill_we = 1'b1;
        fill_wd = fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_rd <= fill_mem[bucket];
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
  end

  always_comb begin
    res_status = ST_MISS;
    if (cur.op == OP_FIND || cur.op == OP_DEL) res_status = found ? ST_HIT : ST_MISS;
    else if (cur.op == OP_ADD)
      res_status = found ? ST_HIT : (fill < FW'(WAYS) ? ST_INSERT : ST_FULL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clearing <= 1'b1;
      clr_idx <= '0;
      total <= '0;
      res_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == (SW+1)'(SLOTS - 1)) clearing <= 1'b0;
      end
      if (done_go) res_pend <= 1'b1;
      else if (res_pend && !out_stall) res_pend <= 1'b0;
      if (state == S_FRONT) begin
        if (cur.op == OP_DEL && found && total != 13'd0) total <= total - 13'd1;
        else if (is_add_new && fill < FW'(WAYS)) total <= total + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur <= in_data;
    if (state == S_DIV && drsp.done) bucket <= drsp.rem[SW-1:0];
    if (state == S_FILL_WAIT) begin
      fill <= (fill_rd > FW'(WAYS)) ? FW'(WAYS) : fill_rd;
      w <= '0;
      found <= 1'b0;
    end
    if (state == S_SCAN_RD && w >= fill) j <= (cur.op == OP_ADD) ? fill : '0;
    if (state == S_SCAN_CHK) begin
      if (key_rd == cur.key) begin
        found <= 1'b1;
        j <= w;
        hold_key <= key_rd;
        hold_val <= val_rd;
      end else w <= w + FW'(1);
    end
    if (state == S_SHIFT_WR) begin
      if (cur.op == OP_DEL && found) j <= j + FW'(1);
      else j <= j - FW'(1);
    end
    if (done_go) begin
      res.status <= res_status;
      res.value_out <= (cur.op == OP_FIND && found) ? hold_val : 32'd0;
      res.entry_count <= total;
    end
  end

  // An add that misses with room in the bucket runs the shift loop from the
  // fill down to the front before the new key is written at the front.
  assign out_valid = res_pend;
  assign out_data = res;

  assert property (@(posedge clk) disable iff (rst) accept |=> state == S_DIV);
  assert property (@(posedge clk) disable iff (rst) clearing |-> in_stall)
    else $error("item accepted during clear");
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> res_pend) else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    res_pend && out_stall |=> res_pend && $stable(res)) else $error("result changed");
endmodule
`default_nettype wire
